// File: hdl/sorted_record_table_assert.svh
// Assertion macros for the checker of the sorted record table.
`ifndef SORTED_RECORD_TABLE_ASSERT_SVH
`define SORTED_RECORD_TABLE_ASSERT_SVH

// Property that must hold in the same cycle as its antecedent.
`define SRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Property whose consequence must hold in the cycle after its antecedent.
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/srt_pkg.sv
// Types, constants and helper functions of the sorted record table.
`default_nettype none
package srt_pkg;

  localparam int unsigned SRT_CAPACITY   = 64;
  localparam int unsigned SRT_KEY_W      = 160;
  localparam int unsigned SRT_IN_DATA_W  = 352;
  localparam int unsigned SRT_OUT_DATA_W = 352;
  localparam int unsigned SRT_COUNT_W    = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_LIST   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;

  typedef struct packed {
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [31:0] key_c;
    logic [63:0] phone_a;
    logic [55:0] phone_b;
    logic [63:0] birth;
  } rec_t;

  typedef enum logic [1:0] {ST_IDLE, ST_DEL, ST_SCAN} state_t;

  typedef enum logic [1:0] {OP_HOLD, OP_INS, OP_DEL, OP_ROT} cell_op_t;

  // Command broadcast to every cell.
  typedef struct packed {
    cell_op_t               op;
    logic [SRT_KEY_W-1:0]   key;
  } ctl_t;

  // Where a cell stands relative to the fill level.
  typedef struct packed {
    logic valid;  // holds a record
    logic tail;   // first free cell
    logic last;   // last occupied cell
  } pos_t;

  function automatic logic [SRT_KEY_W-1:0] rec_key(input rec_t r);
    rec_key = {r.key_a, r.key_b, r.key_c};
  endfunction

  // Zeroes every byte after the first zero byte of a left-aligned text.
  function automatic logic [159:0] clean_text(input logic [159:0] v,
                                              input int unsigned nbytes);
    logic [159:0] o;
    logic         seen;
    o    = v;
    seen = 1'b0;
    for (int i = 0; i < 20; i++) begin
      if (i < nbytes) begin
        if (seen) begin
          o[159-8*i -: 8] = 8'd0;
        end else if (v[159-8*i -: 8] == 8'd0) begin
          seen = 1'b1;
        end
      end
    end
    clean_text = o;
  endfunction

  // Birth month as atoi would read it: (value mod 10000) / 100, which is
  // ten times the thousands digit plus the hundreds digit of the run.
  function automatic logic signed [7:0] birth_month(input logic [63:0] b);
    logic [7:0] c;
    logic       lead;
    logic       stop;
    logic       neg;
    logic [3:0] d0, d1, d2, d3;
    logic [6:0] mag;
    lead = 1'b1;
    stop = 1'b0;
    neg  = 1'b0;
    d0 = 4'd0; d1 = 4'd0; d2 = 4'd0; d3 = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = b[63-8*i -: 8];
      if (!stop) begin
        if (lead && (c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) begin
          lead = 1'b1;
        end else if (lead && (c == 8'h2B || c == 8'h2D)) begin
          lead = 1'b0;
          neg  = (c == 8'h2D);
        end else begin
          lead = 1'b0;
          if (c >= 8'h30 && c <= 8'h39) begin
            d3 = d2; d2 = d1; d1 = d0;
            d0 = 4'(c - 8'h30);
          end else begin
            stop = 1'b1;
          end
        end
      end
    end
    mag = 7'(d3) * 7'd10 + 7'(d2);
    birth_month = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage
`default_nettype wire

// File: hdl/sorted_record_table.sv
// Top level of the sorted record table: a chain of record cells and its sequencer.
//
//   channel | dir | tdata                          | tuser  | tlast
//   in_     | in  | name, phone, birth, query      | mode   | -
//   out_    | out | count, name, phone, birth      | status | last of run
//
// Insert is a single update of the chain: every cell compares the new name with
// its own and the cells above the slot move up one place at once.
// Delete drops the lowest matching record at each step until none is left.
// Find and list rotate the occupied cells once through cell 0, one record
// per cycle when not stalled.
// A result waiting at the output stalls a scan; a new item is taken only when
// the sequencer is idle and the output register is free or being emptied.
// Reset (rst_n low at a clock edge) empties the table; record contents are
// not cleared.
`default_nettype none
module sorted_record_table #(
  parameter int unsigned CAPACITY = srt_pkg::SRT_CAPACITY
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // key_chars_a, key_chars_b, key_chars_c, phone_chars_a, phone_chars_b,
  // birth_chars, query_month
  input  wire logic [srt_pkg::SRT_IN_DATA_W-1:0]  in_tdata,
  // mode
  input  wire logic [1:0]                         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // entry_count, out_key_a, out_key_b, out_key_c, out_phone_a, out_phone_b,
  // out_birth, one zero pad bit
  output logic [srt_pkg::SRT_OUT_DATA_W-1:0]      out_tdata,
  // status
  output logic [1:0]                              out_tuser,
  // last_of_run
  output logic                                    out_tlast
);
  import srt_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [CNT_W-1:0]       k_r, k_nxt;
  logic [SRT_KEY_W-1:0]   key_r, key_nxt;
  logic signed [7:0]      query_r, query_nxt;
  logic                   list_r, list_nxt;
  logic                   pend_v_r, pend_v_nxt;
  rec_t                   pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rec_t                   out_rec_r, out_rec_nxt;
  logic [1:0]             out_stat_r, out_stat_nxt;
  logic [SRT_COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                   out_last_r, out_last_nxt;

  rec_t                   in_rec;
  rec_t                   clean_rec;
  logic [159:0]           clean_name;
  logic [159:0]           clean_phone;
  logic [159:0]           clean_birth;
  logic signed [7:0]      in_query;
  logic                   out_free;
  logic                   any_hit;
  logic                   match;
  ctl_t                   ctl;

  rec_t                   rec_w   [CAPACITY];
  logic                   shift_w [CAPACITY];
  logic [CAPACITY-1:0]    eq_w;

  // Unpack the input item.
  assign in_rec.key_a   = in_tdata[63:0];
  assign in_rec.key_b   = in_tdata[127:64];
  assign in_rec.key_c   = in_tdata[159:128];
  assign in_rec.phone_a = in_tdata[223:160];
  assign in_rec.phone_b = in_tdata[279:224];
  assign in_rec.birth   = in_tdata[343:280];
  assign in_query       = $signed(in_tdata[351:344]);

  // Text after the first zero byte never takes part in ordering or output.
  assign clean_name  = clean_text({in_rec.key_a, in_rec.key_b, in_rec.key_c}, 20);
  assign clean_phone = clean_text({in_rec.phone_a, in_rec.phone_b, 40'd0}, 15);
  assign clean_birth = clean_text({in_rec.birth, 96'd0}, 8);

  assign clean_rec.key_a   = clean_name[159:96];
  assign clean_rec.key_b   = clean_name[95:32];
  assign clean_rec.key_c   = clean_name[31:0];
  assign clean_rec.phone_a = clean_phone[159:96];
  assign clean_rec.phone_b = clean_phone[95:40];
  assign clean_rec.birth   = clean_birth[159:96];

  assign out_free = !out_valid_r || out_tready;
  assign any_hit  = |eq_w;
  // Cell 0 always holds the record under inspection during a scan.
  assign match    = list_r || (birth_month(rec_w[0].birth) == query_r);

  // The cell chain. Records are kept in ascending name order from cell 0.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    pos_t pos;
    rec_t prev_rec;
    rec_t next_rec;
    logic prev_shift;

    assign pos.valid = total_r > CNT_W'(j);
    assign pos.tail  = total_r == CNT_W'(j);
    assign pos.last  = total_r == CNT_W'(j + 1);

    if (j == 0) begin : g_first
      assign prev_rec   = clean_rec;
      assign prev_shift = 1'b0;
    end else begin : g_inner
      assign prev_rec   = rec_w[j-1];
      assign prev_shift = shift_w[j-1];
    end

    if (j == CAPACITY - 1) begin : g_end
      assign next_rec = rec_w[j];
    end else begin : g_mid
      assign next_rec = rec_w[j+1];
    end

    srt_cell u_cell (
      .clk          (clk),
      .ctl_i        (ctl),
      .pos_i        (pos),
      .new_i        (clean_rec),
      .prev_i       (prev_rec),
      .next_i       (next_rec),
      .head_i       (rec_w[0]),
      .prev_shift_i (prev_shift),
      .rec_o        (rec_w[j]),
      .shift_o      (shift_w[j]),
      .eq_o         (eq_w[j])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    k_nxt         = k_r;
    key_nxt       = key_r;
    query_nxt     = query_r;
    list_nxt      = list_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rec_nxt   = out_rec_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    in_tready     = 1'b0;
    ctl.op        = OP_HOLD;
    ctl.key       = key_r;

    case (state_r)
      ST_IDLE: begin
        in_tready = out_free;
        ctl.key   = clean_name;
        if (in_tvalid && out_free) begin
          case (in_tuser)
            MODE_INSERT: begin
              out_valid_nxt = 1'b1;
              out_rec_nxt   = '0;
              out_last_nxt  = 1'b1;
              if (total_r == CNT_W'(CAPACITY)) begin
                out_stat_nxt = STAT_OVERFLOW;
                out_cnt_nxt  = SRT_COUNT_W'(total_r);
              end else begin
                ctl.op       = OP_INS;
                total_nxt    = total_r + CNT_W'(1);
                out_stat_nxt = STAT_OK;
                out_cnt_nxt  = SRT_COUNT_W'(total_r) + SRT_COUNT_W'(1);
              end
            end
            MODE_DELETE: begin
              if (total_r == '0) begin
                out_valid_nxt = 1'b1;
                out_rec_nxt   = '0;
                out_stat_nxt  = STAT_EMPTY;
                out_cnt_nxt   = '0;
                out_last_nxt  = 1'b1;
              end else begin
                key_nxt   = clean_name;
                state_nxt = ST_DEL;
              end
            end
            default: begin
              k_nxt      = '0;
              pend_v_nxt = 1'b0;
              list_nxt   = in_tuser == MODE_LIST;
              query_nxt  = in_query;
              state_nxt  = ST_SCAN;
            end
          endcase
        end
      end

      ST_DEL: begin
        // Matching records sit together, so one drop per cycle clears them.
        if (any_hit) begin
          ctl.op    = OP_DEL;
          total_nxt = total_r - CNT_W'(1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // A hit is held back until the next hit or the end of the scan, so the final one can carry tlast.
        if (k_r == total_r) begin
          if (!pend_v_r) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_rec_nxt   = pend_r;
            out_stat_nxt  = STAT_OK;
            out_cnt_nxt   = '0;
            out_last_nxt  = 1'b1;
            pend_v_nxt    = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end else if (!match || !pend_v_r || out_free) begin
          ctl.op = OP_ROT;
          k_nxt  = k_r + CNT_W'(1);
          if (match) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_rec_nxt   = pend_r;
              out_stat_nxt  = STAT_OK;
              out_cnt_nxt   = '0;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = rec_w[0];
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      k_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      k_r         <= k_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    query_r    <= query_nxt;
    list_r     <= list_nxt;
    pend_r     <= pend_nxt;
    out_rec_r  <= out_rec_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_rec_r.birth, out_rec_r.phone_b, out_rec_r.phone_a,
                       out_rec_r.key_c, out_rec_r.key_b, out_rec_r.key_a, out_cnt_r};

endmodule
`default_nettype wire

// File: hdl/srt_cell.sv
// One cell of the record chain: holds one record and trades it with neighbors.
`default_nettype none
module srt_cell (
  input  wire logic          clk,
  input  wire srt_pkg::ctl_t ctl_i,
  input  wire srt_pkg::pos_t pos_i,
  input  wire srt_pkg::rec_t new_i,
  input  wire srt_pkg::rec_t prev_i,
  input  wire srt_pkg::rec_t next_i,
  input  wire srt_pkg::rec_t head_i,
  input  wire logic          prev_shift_i,
  output srt_pkg::rec_t      rec_o,
  output logic               shift_o,
  output logic               eq_o
);
  import srt_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;
  logic lt;

  assign lt      = ctl_i.key < rec_key(rec_r);
  assign eq_o    = pos_i.valid && (ctl_i.key == rec_key(rec_r));
  assign shift_o = pos_i.valid && lt;
  assign rec_o   = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    case (ctl_i.op)
      OP_INS: begin
        if (shift_o || pos_i.tail) begin
          rec_nxt = prev_shift_i ? prev_i : new_i;
        end
      end
      OP_DEL: begin
        if (pos_i.valid && (lt || eq_o)) begin
          rec_nxt = next_i;
        end
      end
      OP_ROT: begin
        if (pos_i.last) begin
          rec_nxt = head_i;
        end else if (pos_i.valid) begin
          rec_nxt = next_i;
        end
      end
      default: rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/srt_chk.sv
// Port-level checker of the sorted record table and its binding.
`default_nettype none
module srt_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic         out_tlast,
  input wire logic [1:0]   out_tuser,
  input wire logic [351:0] out_tdata
);
  import srt_pkg::*;
  `include "sorted_record_table_assert.svh"

  `SRT_ASSERT_NOW(a_status_only_last, out_tvalid && out_tuser != STAT_OK, out_tlast, "status result without tlast")
  `SRT_ASSERT_NOW(a_empty_no_count, out_tvalid && out_tuser == STAT_EMPTY, out_tdata[6:0] == 7'd0, "empty result with count")
  `SRT_ASSERT_NOW(a_inner_is_record, out_tvalid && !out_tlast, out_tuser == STAT_OK && out_tdata[6:0] == 7'd0, "bad non-final result")
  `SRT_ASSERT_NEXT(a_out_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind sorted_record_table srt_chk u_srt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: sim/tb_sorted_record_table.sv
// Self-checking testbench for the sorted record table: directed and random commands.
`timescale 1ns / 100ps
`default_nettype none
module tb_sorted_record_table;
  import srt_pkg::*;

  // One command as it travels on the input channel.
  typedef struct packed {
    logic [1:0]        mode;
    rec_t              rec;
    logic signed [7:0] query;
  } command_t;

  // One result as it travels on the output channel.
  typedef struct packed {
    logic [1:0] status;
    logic [6:0] count;
    rec_t       rec;
    logic       last;
  } table_reply_t;

  // The scoreboard keeps its own copy of the table and a queue of the
  // replies that the block still owes.
  class table_scoreboard;
    rec_t           rows[SRT_CAPACITY];
    int unsigned    row_total;
    table_reply_t   owed[$];
    int             mismatches;
    int             replies_seen;
    int             overflows;
    int             op_count[4];

    function new();
      row_total    = 0;
      mismatches   = 0;
      replies_seen = 0;
      overflows    = 0;
      op_count     = '{0, 0, 0, 0};
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    // Zeroes every byte after the first zero byte of a left-aligned text.
    function logic [159:0] zap_tail(logic [159:0] v, int nbytes);
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < nbytes; i++) begin
        if (seen) v[159-8*i -: 8] = 8'd0;
        else if (v[159-8*i -: 8] == 8'd0) seen = 1'b1;
      end
      return v;
    endfunction

    // Reads the birth text like atoi and takes (value mod 10000) / 100.
    function int month_of(logic [63:0] b);
      int          i;
      bit          neg;
      int unsigned mag;
      logic [7:0]  c;
      i = 0; neg = 0; mag = 0;
      while (i < 8 && (b[63-8*i -: 8] == 8'd32 ||
             (b[63-8*i -: 8] >= 8'd9 && b[63-8*i -: 8] <= 8'd13))) i++;
      if (i < 8 && (b[63-8*i -: 8] == "+" || b[63-8*i -: 8] == "-")) begin
        neg = (b[63-8*i -: 8] == "-");
        i++;
      end
      while (i < 8) begin
        c = b[63-8*i -: 8];
        if (c < "0" || c > "9") break;
        mag = mag * 10 + (c - "0");
        i++;
      end
      mag = (mag % 10000) / 100;
      return neg ? -int'(mag) : int'(mag);
    endfunction

    function int stored_month(int unsigned idx);
      return month_of(rows[idx].birth);
    endfunction

    function void owe_status(logic [1:0] st, int unsigned cnt);
      table_reply_t r;
      r        = '0;
      r.status = st;
      r.count  = cnt[6:0];
      r.last   = 1'b1;
      owed.push_back(r);
    endfunction

    // Works out what one accepted command must produce.
    function void note_command(command_t c);
      logic [159:0] name, phone, nm, bw;
      rec_t         nr;
      table_reply_t r;
      int unsigned  pos, w;
      int           n;
      op_count[c.mode]++;
      name = zap_tail({c.rec.key_a, c.rec.key_b, c.rec.key_c}, 20);
      case (c.mode)
        MODE_INSERT: begin
          if (row_total >= SRT_CAPACITY) begin
            overflows++;
            owe_status(STAT_OVERFLOW, row_total);
          end else begin
            phone = zap_tail({c.rec.phone_a, c.rec.phone_b, 40'd0}, 15);
            bw    = zap_tail({c.rec.birth, 96'd0}, 8);
            {nr.key_a, nr.key_b, nr.key_c} = name;
            nr.phone_a = phone[159:96];
            nr.phone_b = phone[95:40];
            nr.birth   = bw[159:96];
            pos = row_total;
            while (pos > 0 && name < rec_key(rows[pos-1])) begin
              rows[pos] = rows[pos-1];
              pos--;
            end
            rows[pos] = nr;
            row_total++;
            owe_status(STAT_OK, row_total);
          end
        end
        MODE_DELETE: begin
          if (row_total == 0) begin
            owe_status(STAT_EMPTY, 0);
          end else begin
            w = 0;
            for (int unsigned i = 0; i < row_total; i++) begin
              nm = {rows[i].key_a, rows[i].key_b, rows[i].key_c};
              if (nm != name) begin
                rows[w] = rows[i];
                w++;
              end
            end
            row_total = w;
          end
        end
        default: begin
          n = 0;
          for (int unsigned i = 0; i < row_total; i++) begin
            if (c.mode == MODE_LIST || month_of(rows[i].birth) == int'(c.query)) begin
              r     = '0;
              r.rec = rows[i];
              owed.push_back(r);
              n++;
            end
          end
          if (n > 0) owed[$].last = 1'b1;
        end
      endcase
    endfunction

    // Compares one accepted result with the oldest owed reply.
    task check_reply(table_reply_t got);
      table_reply_t want;
      replies_seen++;
      if (owed.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, 0);
        return;
      end
      want = owed.pop_front();
      if (got.status != want.status) report_mismatch("status", got.status, want.status);
      if (got.count != want.count) report_mismatch("entry_count", got.count, want.count);
      if (got.rec.key_a != want.rec.key_a) report_mismatch("key_a", got.rec.key_a, want.rec.key_a);
      if (got.rec.key_b != want.rec.key_b) report_mismatch("key_b", got.rec.key_b, want.rec.key_b);
      if (got.rec.key_c != want.rec.key_c) report_mismatch("key_c", got.rec.key_c, want.rec.key_c);
      if (got.rec.phone_a != want.rec.phone_a)
        report_mismatch("phone_a", got.rec.phone_a, want.rec.phone_a);
      if (got.rec.phone_b != want.rec.phone_b)
        report_mismatch("phone_b", got.rec.phone_b, want.rec.phone_b);
      if (got.rec.birth != want.rec.birth) report_mismatch("birth", got.rec.birth, want.rec.birth);
      if (got.last != want.last) report_mismatch("last_of_run", got.last, want.last);
    endtask
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [SRT_IN_DATA_W-1:0]  in_tdata;
  logic [1:0]                in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [SRT_OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                out_tuser;
  logic                      out_tlast;

  table_scoreboard sb;
  logic [159:0]    name_pool[6];
  bit              calm;       // no idling in the closing part of the run
  bit              hold_req;   // asks the receiver for one long hold-off

  sorted_record_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Packs an 8-character string left-aligned, zero padded.
  function automatic logic [63:0] text8(string s);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 8; i++) v[63-8*i -: 8] = s[i];
    return v;
  endfunction

  // Random name: mostly from a small pool so that duplicates and deletes hit,
  // sometimes with junk after the terminator, which must not matter.
  function automatic logic [159:0] pick_name();
    logic [159:0] v;
    int           len;
    if ($urandom_range(9) == 0) return {$urandom, $urandom, $urandom, $urandom, $urandom};
    v = name_pool[$urandom_range(5)];
    if ($urandom_range(3) == 0) begin
      len = 0;
      while (len < 20 && v[159-8*len -: 8] != 8'd0) len++;
      for (int i = len + 1; i < 20; i++) v[159-8*i -: 8] = 8'($urandom_range(255));
    end
    return v;
  endfunction

  // Random birth text: blanks, an optional sign and digits, now and then junk.
  function automatic logic [63:0] pick_birth();
    logic [63:0] v;
    int          i;
    v = '0;
    i = 0;
    repeat ($urandom_range(2)) begin
      v[63-8*i -: 8] = ($urandom_range(1) == 0) ? 8'd32 : 8'($urandom_range(13, 9));
      i++;
    end
    if ($urandom_range(2) == 0) begin
      v[63-8*i -: 8] = ($urandom_range(1) == 0) ? "-" : "+";
      i++;
    end
    while (i < 8) begin
      v[63-8*i -: 8] = 8'("0" + $urandom_range(9));
      i++;
    end
    if ($urandom_range(5) == 0) v[63-8*$urandom_range(7) -: 8] = 8'($urandom_range(255));
    return v;
  endfunction

  function automatic command_t make_cmd(logic [1:0] mode, logic [159:0] name,
                                        logic [63:0] birth, logic signed [7:0] q);
    command_t c;
    c.mode = mode;
    {c.rec.key_a, c.rec.key_b, c.rec.key_c} = name;
    c.rec.phone_a = {$urandom, $urandom};
    c.rec.phone_b = 56'({$urandom, $urandom});
    c.rec.birth   = birth;
    c.query       = q;
    return c;
  endfunction

  function automatic command_t random_cmd();
    command_t c;
    int       r;
    int       q;
    r = $urandom_range(99);
    if (r < 8) begin
      c = make_cmd(2'($urandom_range(3)), {$urandom, $urandom, $urandom, $urandom, $urandom},
                   {$urandom, $urandom}, 8'($urandom_range(255)));
    end else if (r < 55) begin
      c = make_cmd(MODE_INSERT, pick_name(), pick_birth(), 8'($urandom_range(255)));
    end else if (r < 72) begin
      c = make_cmd(MODE_DELETE, pick_name(), {$urandom, $urandom}, 8'($urandom_range(255)));
    end else if (r < 88) begin
      if (sb.row_total > 0 && $urandom_range(3) != 0)
        q = sb.stored_month($urandom_range(sb.row_total - 1));
      else
        q = int'($urandom_range(198)) - 99;
      c = make_cmd(MODE_FIND, pick_name(), {$urandom, $urandom}, 8'(q));
    end else begin
      c = make_cmd(MODE_LIST, pick_name(), {$urandom, $urandom}, 8'($urandom_range(255)));
    end
    return c;
  endfunction

  // Offers one command and holds it until the block takes it. Called at a
  // falling edge; returns at a falling edge.
  task automatic send_cmd(command_t c);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= c.mode;
    in_tdata  <= {c.query, c.rec.birth, c.rec.phone_b, c.rec.phone_a,
                  c.rec.key_c, c.rec.key_b, c.rec.key_a};
    do @(posedge clk); while (!in_tready);
    sb.note_command(c);
    @(negedge clk);
    gap = (calm || $urandom_range(2) != 0) ? 0 : $urandom_range(9, 1);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Receiver: random stalls in bursts, free-running stretches in between,
  // and one long hold-off on request so that the table stalls its input.
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        n = 0;
        while (n < 400) begin
          @(negedge clk);
          n++;
        end
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(9, 1) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20) ) begin
          if (hold_req) break;
          @(negedge clk);
        end
      end
    end
  end

  // Output monitor: every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    table_reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.count  = out_tdata[6:0];
      got.rec.key_a   = out_tdata[70:7];
      got.rec.key_b   = out_tdata[134:71];
      got.rec.key_c   = out_tdata[166:135];
      got.rec.phone_a = out_tdata[230:167];
      got.rec.phone_b = out_tdata[286:231];
      got.rec.birth   = out_tdata[350:287];
      got.last        = out_tlast;
      sb.check_reply(got);
    end
  end

  // Stimulus and end of run.
  initial begin
    int waited;
    int len;
    sb        = new();
    calm      = 1'b0;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_INSERT;
    for (int p = 0; p < 6; p++) begin
      name_pool[p] = '0;
      len = $urandom_range(20, 1);
      for (int i = 0; i < len; i++)
        name_pool[p][159-8*i -: 8] = 8'($urandom_range(255, 1));
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty table first, then the edges of names and births.
    send_cmd(make_cmd(MODE_LIST, '0, '0, 0));
    send_cmd(make_cmd(MODE_FIND, '0, '0, 0));
    send_cmd(make_cmd(MODE_DELETE, name_pool[0], '0, 0));
    send_cmd(make_cmd(MODE_INSERT, {160{1'b1}}, {64{1'b1}}, 8'sh7F));
    send_cmd(make_cmd(MODE_INSERT, '0, '0, 8'sh80));
    send_cmd(make_cmd(MODE_INSERT, name_pool[1], text8("19870512"), 0));
    send_cmd(make_cmd(MODE_INSERT, name_pool[1], text8(" -120312"), 0));
    send_cmd(make_cmd(MODE_INSERT, name_pool[1] | 160'hAB, text8("\t+0099"), 0));
    send_cmd(make_cmd(MODE_INSERT, name_pool[2], text8("abc"), 0));
    send_cmd(make_cmd(MODE_INSERT, name_pool[3], text8("\n\r--12"), 0));
    send_cmd(make_cmd(MODE_INSERT, name_pool[4], text8("00009999"), 0));
    send_cmd(make_cmd(MODE_FIND, '0, '0, 5));
    send_cmd(make_cmd(MODE_FIND, '0, '0, -3));
    send_cmd(make_cmd(MODE_FIND, '0, '0, 0));
    send_cmd(make_cmd(MODE_FIND, '0, '0, 99));
    send_cmd(make_cmd(MODE_FIND, '0, '0, -99));
    send_cmd(make_cmd(MODE_LIST, '0, '0, 0));
    send_cmd(make_cmd(MODE_DELETE, name_pool[1], '0, 0));
    send_cmd(make_cmd(MODE_DELETE, name_pool[5] ^ 160'h1, '0, 0));
    send_cmd(make_cmd(MODE_LIST, '0, '0, 0));

    // Fill the table, run into overflow, then list it all while the receiver
    // holds off and more commands keep coming.
    while (sb.row_total < SRT_CAPACITY)
      send_cmd(make_cmd(MODE_INSERT, pick_name(), pick_birth(), 0));
    send_cmd(make_cmd(MODE_INSERT, pick_name(), pick_birth(), 0));
    send_cmd(make_cmd(MODE_INSERT, '0, '0, 0));
    hold_req = 1'b1;
    send_cmd(make_cmd(MODE_LIST, '0, '0, 0));
    send_cmd(make_cmd(MODE_LIST, '0, '0, 0));
    for (int p = 0; p < 6; p++)
      send_cmd(make_cmd(MODE_DELETE, name_pool[p], '0, 0));

    // Random part; the last stretch runs without idling.
    for (int k = 0; k < 40; k++) begin
      if (k == 30) calm = 1'b1;
      send_cmd(random_cmd());
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (sb.owed.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (200) @(negedge clk);
    $display("Commands: %0d insert, %0d delete, %0d find, %0d list; %0d overflows.",
             sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3], sb.overflows);
    $display("Results checked: %0d, still owed: %0d.", sb.replies_seen, sb.owed.size());
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("tb_sorted_record_table: done, clean");
    end else begin
      $display("tb_sorted_record_table: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("tb_sorted_record_table: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
